/* rtl/core/range_minimum_tree_top_macros.svh */
// Assertion macros for the range minimum tree block.
`ifndef RANGE_MINIMUM_TREE_TOP_MACROS_SVH
`define RANGE_MINIMUM_TREE_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RMT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("range_minimum_tree: same-cycle check failed");
// next-cycle implication
`define RMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("range_minimum_tree: next-cycle check failed");
`else
`define RMT_ASSERT_NOW(label, clk, rst, ante, cons)
`define RMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/rmt_pkg.sv */
// Shared types and constants of the range minimum tree block.
`default_nettype none
package rmt_pkg;

   // fixed field widths of the words on the ports
   localparam int INDEX_BITS = 10;
   localparam int FIELD_BITS = 32;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_WRITE,
      ST_LD_MERGE,
      ST_Q_STEP,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_DONE
   } rmt_state_type;

   // one result word
   typedef struct packed {
      logic [FIELD_BITS-1:0] min_value;
      logic                  range_empty;
   } rmt_result_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic clearing;
      logic result_wait;
   } rmt_status_type;

endpackage
`default_nettype wire

/* rtl/core/rmt_node_ram.sv */
// Node store: one write port, one read port, registered read data.
`default_nettype none
module rmt_node_ram #(
   parameter int DEPTH      = 2048,
   parameter int ADDR_BITS  = 11,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_BITS-1:0]  wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0]  rd_addr,
   output logic      [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/rmt_engine.sv */
// Sequencer: clearing pass, leaf load with ancestor refresh, bottom-up range query.
`default_nettype none
module rmt_engine #(
   parameter int LEAF_COUNT = 1024,
   parameter int VALUE_BITS = 32,
   parameter int NODE_BITS  = 11
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request word
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [rmt_pkg::INDEX_BITS-1:0]    req_lo_index,
   input  wire logic [rmt_pkg::INDEX_BITS-1:0]    req_hi_index,
   input  wire logic [rmt_pkg::FIELD_BITS-1:0]    req_load_value,
   // result push toward the output register
   input  wire logic                              slot_free,
   output logic                                   push,
   output rmt_pkg::rmt_result_type                result,
   output rmt_pkg::rmt_status_type                status,
   // node store
   output logic                                   mem_wr_en,
   output logic [NODE_BITS-1:0]                   mem_wr_addr,
   output logic [VALUE_BITS-1:0]                  mem_wr_data,
   output logic [NODE_BITS-1:0]                   mem_rd_addr,
   input  wire logic [VALUE_BITS-1:0]             mem_rd_data
);
   import rmt_pkg::*;

   localparam int PTR_BITS   = NODE_BITS + 1;
   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam logic [31:0] LEAF_COUNT_W = 32'(LEAF_COUNT);
   localparam logic [NODE_BITS-1:0] CLEAR_LAST = NODE_BITS'(NODE_COUNT - 1);

   rmt_state_type         state_ff, state_in;
   logic [PTR_BITS-1:0]   ptr_l_ff, ptr_l_in;
   logic [PTR_BITS-1:0]   ptr_r_ff, ptr_r_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic                  empty_ff, empty_in;
   logic [NODE_BITS-1:0]  clr_ff, clr_in;

   logic [31:0]           lo_w, hi_w, hi_sat_w;
   logic                  lo_ok;
   logic [PTR_BITS-1:0]   l_init, r_init, r_dec;
   logic [VALUE_BITS-1:0] merged;

   // request decode: leaf pointers and saturated upper bound
   always_comb begin
      lo_w     = 32'(req_lo_index);
      hi_w     = 32'(req_hi_index);
      hi_sat_w = (hi_w >= LEAF_COUNT_W) ? (LEAF_COUNT_W - 32'd1) : hi_w;
      lo_ok    = lo_w < LEAF_COUNT_W;
      l_init   = PTR_BITS'(LEAF_COUNT_W + lo_w);
      r_init   = PTR_BITS'(LEAF_COUNT_W + hi_sat_w + 32'd1);
      r_dec    = ptr_r_ff - PTR_BITS'(1);
      merged   = (mem_rd_data < best_ff) ? mem_rd_data : best_ff;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ptr_l_ff <= ptr_l_in;
      ptr_r_ff <= ptr_r_in;
      best_ff  <= best_in;
      empty_ff <= empty_in;
   end

   // next state and store control
   always_comb begin
      state_in    = state_ff;
      ptr_l_in    = ptr_l_ff;
      ptr_r_in    = ptr_r_ff;
      best_in     = best_ff;
      empty_in    = empty_ff;
      clr_in      = clr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_l_ff[NODE_BITS-1:0];
      mem_wr_data = best_ff;
      mem_rd_addr = ptr_l_ff[NODE_BITS-1:0];
      push        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '1;
            clr_in      = clr_ff + NODE_BITS'(1);
            if (clr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_LOAD: begin
                     // out-of-range loads are dropped
                     if (lo_ok) begin
                        ptr_l_in = l_init;
                        best_in  = VALUE_BITS'(req_load_value);
                        state_in = ST_LD_WRITE;
                     end
                  end
                  OP_QUERY: begin
                     best_in = '1;
                     if (req_lo_index > req_hi_index) begin
                        empty_in = 1'b1;
                        state_in = ST_Q_DONE;
                     end else if (!lo_ok) begin
                        empty_in = 1'b0;
                        state_in = ST_Q_DONE;
                     end else begin
                        empty_in = 1'b0;
                        ptr_l_in = l_init;
                        ptr_r_in = r_init;
                        state_in = ST_Q_STEP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // write node, then fetch its sibling unless at the root
         ST_LD_WRITE: begin
            mem_wr_en = 1'b1;
            if (ptr_l_ff == PTR_BITS'(1)) begin
               state_in = ST_IDLE;
            end else begin
               mem_rd_addr = ptr_l_ff[NODE_BITS-1:0] ^ NODE_BITS'(1);
               state_in    = ST_LD_MERGE;
            end
         end
         ST_LD_MERGE: begin
            best_in  = merged;
            ptr_l_in = ptr_l_ff >> 1;
            state_in = ST_LD_WRITE;
         end
         // one level of the half-open interval [l, r)
         ST_Q_STEP: begin
            if (ptr_l_ff >= ptr_r_ff) begin
               state_in = ST_Q_DONE;
            end else if (ptr_l_ff[0]) begin
               mem_rd_addr = ptr_l_ff[NODE_BITS-1:0];
               ptr_l_in    = ptr_l_ff + PTR_BITS'(1);
               state_in    = ST_Q_LEFT;
            end else if (ptr_r_ff[0]) begin
               mem_rd_addr = r_dec[NODE_BITS-1:0];
               ptr_r_in    = r_dec;
               state_in    = ST_Q_RIGHT;
            end else begin
               ptr_l_in = ptr_l_ff >> 1;
               ptr_r_in = ptr_r_ff >> 1;
            end
         end
         ST_Q_LEFT: begin
            best_in = merged;
            if (ptr_r_ff[0]) begin
               mem_rd_addr = r_dec[NODE_BITS-1:0];
               ptr_r_in    = r_dec;
               state_in    = ST_Q_RIGHT;
            end else begin
               ptr_l_in = ptr_l_ff >> 1;
               ptr_r_in = ptr_r_ff >> 1;
               state_in = ST_Q_STEP;
            end
         end
         ST_Q_RIGHT: begin
            best_in  = merged;
            ptr_l_in = ptr_l_ff >> 1;
            ptr_r_in = ptr_r_ff >> 1;
            state_in = ST_Q_STEP;
         end
         ST_Q_DONE: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign result.min_value   = FIELD_BITS'(best_ff);
   assign result.range_empty = empty_ff;
   assign status.clearing    = (state_ff == ST_CLEAR);
   assign status.result_wait = (state_ff == ST_Q_DONE);

endmodule
`default_nettype wire

/* rtl/core/range_minimum_tree_top.sv */
// Top level of the range minimum tree: sequencer, node store, result register.
//
//   channel | direction | handshake       | word
//   --------+-----------+-----------------+----------------------------------------------
//   req_    | in        | valid / stall   | op, lo_index, hi_index, load_value
//   rsp_    | out       | valid / stall   | min_value, range_empty (one per query)
//
// Load: accept, then one write per tree level and one sibling read per level below the
// root, serialized by the single read port. Query: entry, then up to two serialized
// store reads per level, then the closing bound compare and push. After reset a clearing
// pass writes all 2*LEAF_COUNT nodes, one a cycle; req_stall stays high until it ends.
// The next word is taken while a result waits in the rsp_ register.
`default_nettype none
`include "range_minimum_tree_top_macros.svh"
module range_minimum_tree_top #(
   parameter int LEAF_COUNT = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_op,
   input  wire logic [rmt_pkg::INDEX_BITS-1:0] req_lo_index,
   input  wire logic [rmt_pkg::INDEX_BITS-1:0] req_hi_index,
   input  wire logic [rmt_pkg::FIELD_BITS-1:0] req_load_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [rmt_pkg::FIELD_BITS-1:0]      rsp_min_value,
   output logic                                rsp_range_empty
);
   import rmt_pkg::*;

   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam logic [FIELD_BITS-1:0] EMPTY_FIELD = FIELD_BITS'({VALUE_BITS{1'b1}});

   logic                  mem_wr_en;
   logic [NODE_BITS-1:0]  mem_wr_addr;
   logic [VALUE_BITS-1:0] mem_wr_data;
   logic [NODE_BITS-1:0]  mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_rd_data;

   logic                  slot_free;
   logic                  push;
   rmt_result_type        result;
   rmt_status_type        status;

   logic                  rsp_valid_ff;
   rmt_result_type        rsp_word_ff;

   rmt_engine #(
      .LEAF_COUNT (LEAF_COUNT),
      .VALUE_BITS (VALUE_BITS),
      .NODE_BITS  (NODE_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_lo_index   (req_lo_index),
      .req_hi_index   (req_hi_index),
      .req_load_value (req_load_value),
      .slot_free      (slot_free),
      .push           (push),
      .result         (result),
      .status         (status),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   rmt_node_ram #(
      .DEPTH      (NODE_COUNT),
      .ADDR_BITS  (NODE_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result register: free when empty or drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_word_ff.min_value;
   assign rsp_range_empty = rsp_word_ff.range_empty;

   // no words taken while the store is being cleared
   `RMT_ASSERT_NOW(a_clear_blocks_req, clock, reset, status.clearing, req_stall)
   // a push never overwrites a pending result
   `RMT_ASSERT_NOW(a_push_into_free_slot, clock, reset, push, slot_free)
   // a finished query keeps waiting while the result register is blocked
   `RMT_ASSERT_NEXT(a_result_waits, clock, reset, status.result_wait && !slot_free,
      status.result_wait)
   // an empty range always reports the empty value
   `RMT_ASSERT_NOW(a_empty_value, clock, reset, rsp_valid_ff && rsp_word_ff.range_empty,
      rsp_word_ff.min_value == EMPTY_FIELD)

endmodule
`default_nettype wire

/* test/tb_range_minimum_tree_top.sv */
// Testbench for range_minimum_tree_top: directed and random loads and queries vs a min-tree.
module tb_range_minimum_tree_top;
   import rmt_pkg::*;

   localparam int LEAVES       = 1024;
   localparam int RANDOM_WORDS = 750;
   localparam int CALM_WORDS   = 120;   // tail of the random part with no idling
   localparam int HOLD_CYCLES  = 400;   // long receiver hold for the fill-up test
   localparam int DRAIN_CYCLES = 64;    // margin for the last query to finish
   localparam logic [INDEX_BITS-1:0] LAST_LEAF = INDEX_BITS'(LEAVES-1);
   localparam logic [INDEX_BITS-1:0] NEXT_TO_LAST = INDEX_BITS'(LEAVES-2);

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_op         = OP_LOAD;
   logic [INDEX_BITS-1:0] req_lo_index   = '0;
   logic [INDEX_BITS-1:0] req_hi_index   = '0;
   logic [FIELD_BITS-1:0] req_load_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [FIELD_BITS-1:0] rsp_min_value;
   logic                  rsp_range_empty;

   // predictor state: node p holds the minimum of nodes 2p and 2p+1, leaf i at LEAVES+i
   logic [FIELD_BITS-1:0] node_min [0:2*LEAVES-1];
   rmt_result_type        pending_minima [$];

   bit tx_idling = 1'b0;
   bit rx_idling = 1'b0;
   int holds_asked = 0;
   int holds_done  = 0;
   int stall_left  = 0;

   int fail_count    = 0;
   int loads_sent    = 0;
   int queries_sent  = 0;
   int empty_queries = 0;
   int results_seen  = 0;

   range_minimum_tree_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_lo_index    (req_lo_index),
      .req_hi_index    (req_hi_index),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_min_value   (rsp_min_value),
      .rsp_range_empty (rsp_range_empty)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // write one leaf and refresh its ancestors
   function automatic void tree_load(input logic [INDEX_BITS-1:0] leaf,
                                     input logic [FIELD_BITS-1:0] value);
      int unsigned p;
      p = LEAVES + leaf;
      node_min[p] = value;
      while (p > 1) begin
         p = p >> 1;
         node_min[p] = (node_min[2*p] < node_min[2*p+1]) ? node_min[2*p] : node_min[2*p+1];
      end
   endfunction

   // bottom-up climb over the half-open node interval [l, r); hi never exceeds the last leaf
   function automatic rmt_result_type tree_range_min(input logic [INDEX_BITS-1:0] lo,
                                                     input logic [INDEX_BITS-1:0] hi);
      rmt_result_type res;
      int unsigned    l;
      int unsigned    r;
      logic [FIELD_BITS-1:0] best;
      best = '1;
      res.range_empty = (lo > hi);
      if (!res.range_empty) begin
         l = LEAVES + lo;
         r = LEAVES + hi + 1;
         while (l < r) begin
            if ((l & 1) != 0) begin
               if (node_min[l] < best) best = node_min[l];
               l = l + 1;
            end
            if ((r & 1) != 0) begin
               r = r - 1;
               if (node_min[r] < best) best = node_min[r];
            end
            l = l >> 1;
            r = r >> 1;
         end
      end
      res.min_value = best;
      return res;
   endfunction

   task automatic note_error(input string what, input logic [FIELD_BITS-1:0] want,
                             input logic [FIELD_BITS-1:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
   endtask

   // offer one word, wait for it to be taken, then update the predictor
   task automatic send_word(input logic op, input logic [INDEX_BITS-1:0] lo,
                            input logic [INDEX_BITS-1:0] hi,
                            input logic [FIELD_BITS-1:0] value);
      int gap;
      if (tx_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_lo_index   <= lo;
      req_hi_index   <= hi;
      req_load_value <= value;
      do @(posedge clock); while (req_stall);
      if (op == OP_LOAD) begin
         tree_load(lo, value);
         loads_sent++;
      end else begin
         pending_minima.push_back(tree_range_min(lo, hi));
         queries_sent++;
         if (lo > hi) empty_queries++;
      end
   endtask

   task automatic send_query(input logic [INDEX_BITS-1:0] lo, input logic [INDEX_BITS-1:0] hi);
      send_word(OP_QUERY, lo, hi, $urandom);
   endtask

   task automatic send_load(input logic [INDEX_BITS-1:0] leaf, input logic [FIELD_BITS-1:0] v);
      send_word(OP_LOAD, leaf, INDEX_BITS'($urandom_range(0, LEAVES-1)), v);
   endtask

   // receiver pacing: random stall bursts, plus a long hold when one is asked for
   always @(posedge clock) begin : receiver_pacing
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         stall_left <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 17);
         rsp_stall  <= 1'b1;
      end
   end

   // compare each taken result word with the oldest expectation
   always @(posedge clock) begin : result_check
      rmt_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_minima.size() == 0) begin
            note_error("unexpected result, min_value", '0, rsp_min_value);
         end else begin
            want = pending_minima.pop_front();
            if (rsp_min_value !== want.min_value)
               note_error("min_value", want.min_value, rsp_min_value);
            if (rsp_range_empty !== want.range_empty)
               note_error("range_empty", FIELD_BITS'(want.range_empty),
                          FIELD_BITS'(rsp_range_empty));
         end
      end
   end

   // queries on the freshly cleared tree, including empty ranges
   task automatic test_cleared_tree();
      send_query(0, LAST_LEAF);
      send_query(LAST_LEAF, 0);
      send_query(512, 511);
      send_query(7, 7);
   endtask

   // extreme values and leaves, sibling boundaries, overwrites that raise the minimum
   task automatic test_directed();
      send_load(0, 32'h8000_0000);
      send_load(LAST_LEAF, 32'h0000_0000);
      send_load(1, 32'hFFFF_FFFF);
      send_load(511, 32'd5);
      send_load(512, 32'd7);
      send_load(2, 32'd1);
      send_query(0, 0);
      send_query(LAST_LEAF, LAST_LEAF);
      send_query(0, NEXT_TO_LAST);
      send_query(1, 1);
      send_query(3, 510);
      send_query(511, 512);
      send_query(512, NEXT_TO_LAST);
      send_query(0, LAST_LEAF);
      send_query(2, 3);
      send_load(LAST_LEAF, 32'hFFFF_FFFF);
      send_query(0, LAST_LEAF);
      send_load(2, 32'hFFFF_FFFF);
      send_query(0, 510);
   endtask

   // random loads and queries; loads dominate early so queries see a populated tree
   task automatic test_random();
      logic [INDEX_BITS-1:0] lo;
      logic [INDEX_BITS-1:0] hi;
      logic [FIELD_BITS-1:0] v;
      int pick;
      int span;
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - CALM_WORDS) begin
            tx_idling = 1'b0;
            rx_idling = 1'b0;
         end
         if ($urandom_range(0, 99) < ((i < 150) ? 75 : 35)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      v = $urandom;
            else if (pick < 9) v = $urandom_range(0, 4095);
            else               v = '1;
            send_load(INDEX_BITS'($urandom_range(0, LEAVES-1)), v);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               lo = INDEX_BITS'($urandom_range(1, LEAVES-1));
               hi = INDEX_BITS'($urandom_range(0, lo - 1));
            end else if (pick == 1) begin
               lo = INDEX_BITS'($urandom_range(0, 15));
               hi = INDEX_BITS'($urandom_range(LEAVES-16, LEAVES-1));
            end else begin
               lo   = INDEX_BITS'($urandom_range(0, LEAVES-1));
               span = $urandom_range(0, 63);
               hi   = (int'(lo) + span > LEAVES-1) ? LAST_LEAF
                                                   : INDEX_BITS'(int'(lo) + span);
            end
            send_query(lo, hi);
         end
      end
   endtask

   // long receiver hold while queries keep coming, so the block backs up into its input
   task automatic test_backpressure();
      tx_idling = 1'b0;
      holds_asked++;
      for (int i = 0; i < 30; i++)
         send_query(INDEX_BITS'($urandom_range(0, 511)),
                    INDEX_BITS'($urandom_range(512, LEAVES-1)));
   endtask

   initial begin
      foreach (node_min[n]) node_min[n] = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_cleared_tree();
      test_directed();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (pending_minima.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_minima.size() != 0) note_error("missing result, count", '0, '0);
      $display("run covered %0d loads and %0d queries (%0d empty ranges), %0d results checked,",
               loads_sent, queries_sent, empty_queries, results_seen);
      $display("with random stall bursts on both sides and one long receiver hold");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* range_minimum_tree_top.f */
+incdir+rtl/core
rtl/core/rmt_pkg.sv
rtl/core/rmt_node_ram.sv
rtl/core/rmt_engine.sv
rtl/core/range_minimum_tree_top.sv
test/tb_range_minimum_tree_top.sv
